>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants and types of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  // default region and minimum block size, as powers of two
  localparam int MaxPowerDefault = 16;
  localparam int MinPowerDefault = 4;

  // port widths fixed by the item formats
  localparam int SizeWidth   = 17;
  localparam int OffsetWidth = 16;
  localparam int LevelWidth  = 4;
  localparam int StatusWidth = 2;
  localparam int StampWidth  = 32;

  // node conditions
  localparam logic [1:0] CondNonExist = 2'd0;
  localparam logic [1:0] CondFree     = 2'd1;
  localparam logic [1:0] CondSplit    = 2'd2;
  localparam logic [1:0] CondOccupied = 2'd3;

  // result status codes
  localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
  localparam logic [StatusWidth-1:0] StatusNoSpace  = 2'd1;
  localparam logic [StatusWidth-1:0] StatusNotAlloc = 2'd2;

  // action codes
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // control of the tree memories
  typedef struct packed {
    logic cond_we;
    logic stamp_we;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> rtl/bba_tree_mem.sv
// ----------------------------------------------------------------------------
// bba_tree_mem
// node condition and free stamp memories, one write and one read port each
// ----------------------------------------------------------------------------
module bba_tree_mem #(
  parameter int AddrWidth = 13,
  parameter int Nodes     = 8191
) (
  input  logic                              clk_i,
  input  bba_pkg::mem_ctl_t                 ctl_i,
  input  logic [AddrWidth-1:0]              wr_addr_i,
  input  logic [1:0]                        cond_wdata_i,
  input  logic [bba_pkg::StampWidth-1:0]    stamp_wdata_i,
  input  logic [AddrWidth-1:0]              rd_addr_i,
  output logic [1:0]                        cond_rdata_o,
  output logic [bba_pkg::StampWidth-1:0]    stamp_rdata_o
);

  logic [1:0]                     cond_mem [Nodes];
  logic [bba_pkg::StampWidth-1:0] stamp_mem [Nodes];

  // condition memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.cond_we) begin
      cond_mem[wr_addr_i] <= cond_wdata_i;
    end
    if (ctl_i.rd_en) begin
      cond_rdata_o <= cond_mem[rd_addr_i];
    end
  end

  // stamp memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.stamp_we) begin
      stamp_mem[wr_addr_i] <= stamp_wdata_i;
    end
    if (ctl_i.rd_en) begin
      stamp_rdata_o <= stamp_mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy tree manager: allocate and free power-of-two blocks of a region
// ----------------------------------------------------------------------------
// Input channel: action, request_size and byte_offset move on a transfer of
// in_valid_i while in_stall_o is low. Output channel: status, block_offset
// and block_level move on a transfer of out_valid_o while out_stall_i is low.
// One result per request. Requests are worked one at a time; in_stall_o is
// high while a request is in progress.
// Allocate scans the tree levels from the target level upward, each node visited
// in a memory read state and then a compare state (StARead, StAEval), then
// splits down to the target level. Free reads up to LEVELS+1 nodes on its way
// up; each merge passes through StMRead, StMEval, StMClr1, StMClr2, StMPar.
// Nodes are read one at a time through the single read port of the memories.
// After reset the block runs a clearing pass over all 2^(LEVELS+1)-1 nodes
// (8191 with the defaults) of the condition memory, stalling its input.
// A result waits in the output register while the receiver stalls; the next
// request is taken meanwhile and holds at its end until the register frees.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int MAX_POWER = bba_pkg::MaxPowerDefault,
  parameter int MIN_POWER = bba_pkg::MinPowerDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [bba_pkg::SizeWidth-1:0]     request_size_i,
  input  logic [bba_pkg::OffsetWidth-1:0]   byte_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bba_pkg::StatusWidth-1:0]   status_o,
  output logic [bba_pkg::OffsetWidth-1:0]   block_offset_o,
  output logic [bba_pkg::LevelWidth-1:0]    block_level_o
);

  localparam int Levels = MAX_POWER - MIN_POWER;
  localparam int PW     = (Levels > 0) ? Levels : 1;
  localparam int IW     = Levels + 1;
  localparam int Nodes  = (2 ** (Levels + 1)) - 1;
  localparam int LW     = $clog2(Levels + 1) > 0 ? $clog2(Levels + 1) : 1;
  localparam int SW     = bba_pkg::StampWidth;

  localparam logic [3:0] StClear  = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StARead  = 4'd2;
  localparam logic [3:0] StAEval  = 4'd3;
  localparam logic [3:0] StASplit = 4'd4;
  localparam logic [3:0] StABud   = 4'd5;
  localparam logic [3:0] StAOcc   = 4'd6;
  localparam logic [3:0] StFRead  = 4'd7;
  localparam logic [3:0] StFEval  = 4'd8;
  localparam logic [3:0] StFMark  = 4'd9;
  localparam logic [3:0] StMRead  = 4'd10;
  localparam logic [3:0] StMEval  = 4'd11;
  localparam logic [3:0] StMClr1  = 4'd12;
  localparam logic [3:0] StMClr2  = 4'd13;
  localparam logic [3:0] StMPar   = 4'd14;
  localparam logic [3:0] StDone   = 4'd15;

  logic [3:0]      state_q, state_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [LW-1:0]   tgt_q, tgt_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW:0]     scan_q, scan_d;
  logic            found_q, found_d;
  logic [PW-1:0]   best_q, best_d;
  logic [SW-1:0]   best_age_q, best_age_d;
  logic [SW-1:0]   stamp_cnt_q, stamp_cnt_d;
  logic [bba_pkg::StatusWidth-1:0] res_status_q, res_status_d;
  logic [PW-1:0]   res_pos_q, res_pos_d;
  logic [LW-1:0]   res_lvl_q, res_lvl_d;
  logic            out_valid_q, out_valid_d;
  logic [bba_pkg::StatusWidth-1:0] status_q, status_d;
  logic [bba_pkg::OffsetWidth-1:0] offset_q, offset_d;
  logic [bba_pkg::LevelWidth-1:0]  level_q, level_d;

  bba_pkg::mem_ctl_t mem_ctl;
  logic [IW-1:0]   wr_addr, rd_addr;
  logic [1:0]      cond_wdata, cond_rdata;
  logic [SW-1:0]   stamp_rdata;

  logic [5:0]      power;
  logic [SW-1:0]   age;
  logic [PW:0]     scan_last;
  logic [63:0]     off_wide;
  logic [63:0]     free_off;

  // node index of (level, position)
  function automatic logic [IW-1:0] node_idx(input logic [LW-1:0] d, input logic [PW-1:0] p);
    node_idx = ((IW'(1) << d) - IW'(1)) + IW'(p);
  endfunction

  // request size rounded up to a power of two, at least 2^MIN_POWER
  always_comb begin
    logic [bba_pkg::SizeWidth-1:0] sm1;
    sm1   = request_size_i - bba_pkg::SizeWidth'(1);
    power = 6'd0;
    if (request_size_i > bba_pkg::SizeWidth'(1)) begin
      for (int b = 0; b < bba_pkg::SizeWidth; b++) begin
        if (sm1[b]) power = 6'(b + 1);
      end
    end
    if (32'(power) < 32'(MIN_POWER)) power = 6'(MIN_POWER);
  end

  assign age       = stamp_cnt_q - stamp_rdata;
  assign scan_last = ((PW + 1)'(1) << lvl_q) - (PW + 1)'(1);
  assign off_wide  = 64'(res_pos_q) << (MAX_POWER - 32'(res_lvl_q));
  assign free_off  = (64'(byte_offset_i) & ((64'(1) << MAX_POWER) - 64'(1))) >> MIN_POWER;

  // control sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    lvl_d        = lvl_q;
    tgt_d        = tgt_q;
    pos_d        = pos_q;
    scan_d       = scan_q;
    found_d      = found_q;
    best_d       = best_q;
    best_age_d   = best_age_q;
    stamp_cnt_d  = stamp_cnt_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_lvl_d    = res_lvl_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    offset_d     = offset_q;
    level_d      = level_q;
    mem_ctl      = '0;
    wr_addr      = node_idx(lvl_q, pos_q);
    rd_addr      = node_idx(lvl_q, pos_q);
    cond_wdata   = bba_pkg::CondFree;

    // output register empties on a transfer
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      StClear: begin
        mem_ctl.cond_we  = 1'b1;
        mem_ctl.stamp_we = (clr_q == '0);
        wr_addr          = clr_q;
        cond_wdata       = (clr_q == '0) ? bba_pkg::CondFree : bba_pkg::CondNonExist;
        clr_d            = clr_q + IW'(1);
        if (clr_q == IW'(Nodes - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          res_status_d = bba_pkg::StatusOk;
          res_pos_d    = '0;
          res_lvl_d    = '0;
          if (action_i == bba_pkg::ActAlloc) begin
            if (32'(power) > 32'(MAX_POWER)) begin
              res_status_d = bba_pkg::StatusNoSpace;
              state_d      = StDone;
            end else begin
              tgt_d   = LW'(MAX_POWER - 32'(power));
              lvl_d   = LW'(MAX_POWER - 32'(power));
              scan_d  = '0;
              found_d = 1'b0;
              state_d = StARead;
            end
          end else begin
            lvl_d   = LW'(Levels);
            pos_d   = PW'(free_off);
            state_d = StFRead;
          end
        end
      end
      StARead: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = node_idx(lvl_q, PW'(scan_q));
        state_d       = StAEval;
      end
      StAEval: begin
        if (cond_rdata == bba_pkg::CondFree && (!found_q || age > best_age_q)) begin
          found_d    = 1'b1;
          best_d     = PW'(scan_q);
          best_age_d = age;
        end
        if (scan_q == scan_last) begin
          if (found_d) begin
            pos_d   = best_d;
            state_d = (lvl_q < tgt_q) ? StASplit : StAOcc;
          end else if (lvl_q == '0) begin
            res_status_d = bba_pkg::StatusNoSpace;
            state_d      = StDone;
          end else begin
            lvl_d   = lvl_q - LW'(1);
            scan_d  = '0;
            state_d = StARead;
          end
        end else begin
          scan_d  = scan_q + (PW + 1)'(1);
          state_d = StARead;
        end
      end
      StASplit: begin
        mem_ctl.cond_we = 1'b1;
        cond_wdata      = bba_pkg::CondSplit;
        lvl_d           = lvl_q + LW'(1);
        pos_d           = pos_q << 1;
        state_d         = StABud;
      end
      StABud: begin
        mem_ctl.cond_we  = 1'b1;
        mem_ctl.stamp_we = 1'b1;
        wr_addr          = node_idx(lvl_q, pos_q | PW'(1));
        stamp_cnt_d      = stamp_cnt_q + SW'(1);
        state_d          = (lvl_q < tgt_q) ? StASplit : StAOcc;
      end
      StAOcc: begin
        mem_ctl.cond_we = 1'b1;
        cond_wdata      = bba_pkg::CondOccupied;
        res_pos_d       = pos_q;
        res_lvl_d       = lvl_q;
        state_d         = StDone;
      end
      StFRead: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = StFEval;
      end
      StFEval: begin
        if (cond_rdata == bba_pkg::CondOccupied) begin
          state_d = StFMark;
        end else if (lvl_q == '0) begin
          res_status_d = bba_pkg::StatusNotAlloc;
          state_d      = StDone;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          pos_d   = pos_q >> 1;
          state_d = StFRead;
        end
      end
      StFMark: begin
        mem_ctl.cond_we  = 1'b1;
        mem_ctl.stamp_we = 1'b1;
        stamp_cnt_d      = stamp_cnt_q + SW'(1);
        res_pos_d        = pos_q;
        res_lvl_d        = lvl_q;
        state_d          = (lvl_q == '0) ? StDone : StMRead;
      end
      StMRead: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = node_idx(lvl_q, pos_q ^ PW'(1));
        state_d       = StMEval;
      end
      StMEval: begin
        state_d = (cond_rdata == bba_pkg::CondFree) ? StMClr1 : StDone;
      end
      StMClr1: begin
        mem_ctl.cond_we = 1'b1;
        cond_wdata      = bba_pkg::CondNonExist;
        state_d         = StMClr2;
      end
      StMClr2: begin
        mem_ctl.cond_we = 1'b1;
        cond_wdata      = bba_pkg::CondNonExist;
        wr_addr         = node_idx(lvl_q, pos_q ^ PW'(1));
        lvl_d           = lvl_q - LW'(1);
        pos_d           = pos_q >> 1;
        state_d         = StMPar;
      end
      StMPar: begin
        mem_ctl.cond_we  = 1'b1;
        mem_ctl.stamp_we = 1'b1;
        stamp_cnt_d      = stamp_cnt_q + SW'(1);
        state_d          = (lvl_q == '0) ? StDone : StMRead;
      end
      StDone: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          offset_d    = off_wide[bba_pkg::OffsetWidth-1:0];
          level_d     = bba_pkg::LevelWidth'(res_lvl_q);
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      stamp_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      stamp_cnt_q <= stamp_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    lvl_q        <= lvl_d;
    tgt_q        <= tgt_d;
    pos_q        <= pos_d;
    scan_q       <= scan_d;
    found_q      <= found_d;
    best_q       <= best_d;
    best_age_q   <= best_age_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_lvl_q    <= res_lvl_d;
    status_q     <= status_d;
    offset_q     <= offset_d;
    level_q      <= level_d;
  end

  bba_tree_mem #(
    .AddrWidth (IW),
    .Nodes     (Nodes)
  ) u_mem (
    .clk_i         (clk_i),
    .ctl_i         (mem_ctl),
    .wr_addr_i     (wr_addr),
    .cond_wdata_i  (cond_wdata),
    .stamp_wdata_i (stamp_cnt_q),
    .rd_addr_i     (rd_addr),
    .cond_rdata_o  (cond_rdata),
    .stamp_rdata_o (stamp_rdata)
  );

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_offset_o = offset_q;
  assign block_level_o  = level_q;

endmodule

>>> rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// port level checks of the buddy block allocator
// ----------------------------------------------------------------------------
module bba_checker #(
  parameter int MAX_POWER = bba_pkg::MaxPowerDefault,
  parameter int MIN_POWER = bba_pkg::MinPowerDefault
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [bba_pkg::StatusWidth-1:0]   status_o,
  input logic [bba_pkg::OffsetWidth-1:0]   block_offset_o,
  input logic [bba_pkg::LevelWidth-1:0]    block_level_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(block_offset_o) && $stable(block_level_o))
    else $error("stalled result changed");

  // error results carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bba_pkg::StatusOk |->
      block_offset_o == '0 && block_level_o == '0)
    else $error("error result with nonzero fields");

  // no undefined status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == bba_pkg::StatusOk || status_o == bba_pkg::StatusNoSpace
      || status_o == bba_pkg::StatusNotAlloc)
    else $error("bad status code");

  // accepted request blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // level within tree depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(block_level_o) <= MAX_POWER - MIN_POWER)
    else $error("level beyond tree depth");

endmodule

bind buddy_block_allocator bba_checker #(
  .MAX_POWER (MAX_POWER),
  .MIN_POWER (MIN_POWER)
) u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .block_offset_o (block_offset_o),
  .block_level_o  (block_level_o)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the buddy block allocator against an in-bench model of the buddy
// tree: directed corner requests first, then random allocate/free traffic
// with random idle and stall bursts on both channels
// ----------------------------------------------------------------------------
module testbench;

  localparam int Levels    = bba_pkg::MaxPowerDefault - bba_pkg::MinPowerDefault;
  localparam int NodeCount = (1 << (Levels + 1)) - 1;
  localparam int RandomCount = 850;

  typedef struct packed {
    logic [bba_pkg::StatusWidth-1:0] status;
    logic [bba_pkg::OffsetWidth-1:0] offset;
    logic [bba_pkg::LevelWidth-1:0]  level;
  } block_result_t;

  typedef struct {
    int offset;
    int level;
  } live_block_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            action_i = bba_pkg::ActAlloc;
  logic [bba_pkg::SizeWidth-1:0]   request_size_i = '0;
  logic [bba_pkg::OffsetWidth-1:0] byte_offset_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [bba_pkg::StatusWidth-1:0] status_o;
  logic [bba_pkg::OffsetWidth-1:0] block_offset_o;
  logic [bba_pkg::LevelWidth-1:0]  block_level_o;

  // shadow buddy tree
  logic [1:0]  tree_cond [NodeCount];
  logic [31:0] tree_stamp [NodeCount];
  logic [31:0] stamp_count;

  block_result_t expected_q[$];
  live_block_t   live_blocks[$];
  bit idle_en = 1'b1;
  int mismatch_count = 0;
  int result_count = 0;
  int alloc_count = 0;
  int free_count = 0;
  int stall_left = 0;

  buddy_block_allocator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .request_size_i,
    .byte_offset_i, .out_valid_o, .out_stall_i, .status_o, .block_offset_o,
    .block_level_o
  );

  always #10 clk_i = ~clk_i;

  function automatic int node_idx(int d, int p);
    return (1 << d) - 1 + p;
  endfunction

  function automatic void mark_free(int idx);
    tree_cond[idx] = bba_pkg::CondFree;
    tree_stamp[idx] = stamp_count;
    stamp_count = stamp_count + 1;
  endfunction

  // allocate: oldest free node from the target depth upward, then split down
  function automatic block_result_t predict_alloc(logic [bba_pkg::SizeWidth-1:0] size);
    block_result_t r;
    int pw;
    int target;
    int d;
    int p;
    int best;
    bit found;
    logic [31:0] age;
    logic [31:0] best_age;
    r = '0;
    r.status = bba_pkg::StatusNoSpace;
    pw = 0;
    while (pw < 40 && (longint'(1) << pw) < longint'(size)) pw++;
    if (pw < bba_pkg::MinPowerDefault) pw = bba_pkg::MinPowerDefault;
    if (pw > bba_pkg::MaxPowerDefault) return r;
    target = bba_pkg::MaxPowerDefault - pw;
    for (d = target; d >= 0; d--) begin
      found = 1'b0;
      best = 0;
      best_age = '0;
      for (int q = 0; q < (1 << d); q++) begin
        if (tree_cond[node_idx(d, q)] == bba_pkg::CondFree) begin
          age = stamp_count - tree_stamp[node_idx(d, q)];
          if (!found || age > best_age) begin
            found = 1'b1;
            best = q;
            best_age = age;
          end
        end
      end
      if (found) begin
        p = best;
        while (d < target) begin
          tree_cond[node_idx(d, p)] = bba_pkg::CondSplit;
          d++;
          p = p * 2;
          mark_free(node_idx(d, p + 1));
        end
        tree_cond[node_idx(d, p)] = bba_pkg::CondOccupied;
        r.status = bba_pkg::StatusOk;
        r.offset = bba_pkg::OffsetWidth'(p << (bba_pkg::MaxPowerDefault - d));
        r.level = bba_pkg::LevelWidth'(d);
        return r;
      end
    end
    return r;
  endfunction

  // free: occupied ancestor of the offset, then merge free buddies upward
  function automatic block_result_t predict_free(logic [bba_pkg::OffsetWidth-1:0] off);
    block_result_t r;
    int d;
    int p;
    int pp;
    r = '0;
    d = Levels;
    p = int'(off) >> bba_pkg::MinPowerDefault;
    while (tree_cond[node_idx(d, p)] != bba_pkg::CondOccupied) begin
      if (d == 0) begin
        r.status = bba_pkg::StatusNotAlloc;
        return r;
      end
      d--;
      p = p >> 1;
    end
    mark_free(node_idx(d, p));
    r.status = bba_pkg::StatusOk;
    r.offset = bba_pkg::OffsetWidth'(p << (bba_pkg::MaxPowerDefault - d));
    r.level = bba_pkg::LevelWidth'(d);
    while (d > 0) begin
      pp = p >> 1;
      if (tree_cond[node_idx(d, 2 * pp)] != bba_pkg::CondFree ||
          tree_cond[node_idx(d, 2 * pp + 1)] != bba_pkg::CondFree) break;
      tree_cond[node_idx(d, 2 * pp)] = bba_pkg::CondNonExist;
      tree_cond[node_idx(d, 2 * pp + 1)] = bba_pkg::CondNonExist;
      d--;
      p = pp;
      mark_free(node_idx(d, p));
    end
    return r;
  endfunction

  // one request transfer, with an optional idle burst in front
  task automatic send_request(logic act, logic [bba_pkg::SizeWidth-1:0] size,
                              logic [bba_pkg::OffsetWidth-1:0] off);
    block_result_t r;
    live_block_t   lb;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    request_size_i <= size;
    byte_offset_i <= off;
    do @(posedge clk_i); while (in_stall_o);
    if (act == bba_pkg::ActAlloc) begin
      r = predict_alloc(size);
      alloc_count++;
      if (r.status == bba_pkg::StatusOk) begin
        lb.offset = int'(r.offset);
        lb.level = int'(r.level);
        live_blocks.insert(live_blocks.size(), lb);
      end
    end else begin
      r = predict_free(off);
      free_count++;
      if (r.status == bba_pkg::StatusOk) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i].offset == int'(r.offset) &&
              live_blocks[i].level == int'(r.level)) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  // result check and receiver stall bursts
  always @(posedge clk_i) begin
    block_result_t e;
    if (out_valid_o && !out_stall_i) begin
      result_count++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d", status_o);
        mismatch_count++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          mismatch_count++;
        end
        if (block_offset_o !== e.offset) begin
          $error("block_offset: expected %0d, got %0d", e.offset, block_offset_o);
          mismatch_count++;
        end
        if (block_level_o !== e.level) begin
          $error("block_level: expected %0d, got %0d", e.level, block_level_o);
          mismatch_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // whole region, full tree, too-large and unallocated frees
  task automatic test_region_limits();
    send_request(bba_pkg::ActAlloc, 17'd65536, '0);
    send_request(bba_pkg::ActAlloc, 17'd16, '0);
    send_request(bba_pkg::ActFree, '0, 16'd12345);
    send_request(bba_pkg::ActFree, '0, 16'd12345);
    send_request(bba_pkg::ActAlloc, 17'd65537, '0);
    send_request(bba_pkg::ActAlloc, 17'h1FFFF, '0);
    send_request(bba_pkg::ActFree, '0, 16'hFFFF);
  endtask

  // minimum-size rounding of zero and one, odd sizes, buddy splits and merges
  task automatic test_size_rounding();
    send_request(bba_pkg::ActAlloc, 17'd0, '0);
    send_request(bba_pkg::ActAlloc, 17'd1, '0);
    send_request(bba_pkg::ActAlloc, 17'd16, '0);
    send_request(bba_pkg::ActAlloc, 17'd17, '0);
    send_request(bba_pkg::ActAlloc, 17'd32768, '0);
    send_request(bba_pkg::ActAlloc, 17'd32769, '0);
    send_request(bba_pkg::ActFree, '0, 16'hFFFF);
    // free the live blocks from an inner byte, forcing merges
    while (live_blocks.size() > 0)
      send_request(bba_pkg::ActFree, '0,
                   bba_pkg::OffsetWidth'(live_blocks[0].offset + 3));
    send_request(bba_pkg::ActAlloc, 17'd65536, '0);
    send_request(bba_pkg::ActFree, '0, 16'h0000);
  endtask

  // random traffic, mostly large blocks since deep scans are slow
  task automatic test_random_traffic();
    int r;
    int lvl;
    int bsz;
    for (int n = 0; n < RandomCount; n++) begin
      if (n == RandomCount - 100) idle_en = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 42 && live_blocks.size() > 0) begin
        r = $urandom_range(0, live_blocks.size() - 1);
        bsz = 1 << (bba_pkg::MaxPowerDefault - live_blocks[r].level);
        send_request(bba_pkg::ActFree, '0,
                     bba_pkg::OffsetWidth'(live_blocks[r].offset +
                                           $urandom_range(0, bsz - 1)));
      end else if (r < 52) begin
        send_request(bba_pkg::ActFree, '0, bba_pkg::OffsetWidth'($urandom));
      end else if (r < 54) begin
        send_request(bba_pkg::ActAlloc,
                     bba_pkg::SizeWidth'($urandom_range(65537, 131071)), '0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) lvl = $urandom_range(10, Levels);
        else if (r < 12) lvl = $urandom_range(7, 9);
        else lvl = $urandom_range(0, 6);
        bsz = 1 << (bba_pkg::MaxPowerDefault - lvl);
        send_request(bba_pkg::ActAlloc,
                     bba_pkg::SizeWidth'($urandom_range(bsz / 2 + 1, bsz)),
                     bba_pkg::OffsetWidth'($urandom));
      end
    end
  endtask

  initial begin
    foreach (tree_cond[i]) begin
      tree_cond[i] = bba_pkg::CondNonExist;
      tree_stamp[i] = '0;
    end
    tree_cond[0] = bba_pkg::CondFree;
    stamp_count = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_region_limits();
    test_size_rounding();
    test_random_traffic();
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d allocate and %0d free transfers, %0d results checked",
             alloc_count, free_count, result_count);
    $display("%0d blocks still held at the end", live_blocks.size());
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // timeout
  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bba_pkg.sv
rtl/bba_tree_mem.sv
rtl/buddy_block_allocator.sv
rtl/bba_checker.sv
tb/testbench.sv
